// File: hw/rtl/sha_pkg.sv
package sha_pkg;

   localparam int WordWidth  = 32;
   localparam int CountWidth = 61;
   localparam int Rounds     = 64;
   localparam int WinDepth   = 16;

   localparam logic [7:0] PadByte = 8'h80;

   typedef enum logic [0:0] {
      OP_BYTE   = 1'b0,
      OP_FINISH = 1'b1
   } op_type;

   typedef struct packed {
      logic [31:0] hash_word;
      logic [2:0]  word_index;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic op;
      logic [7:0] data_byte;
   } req_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] round_const(input logic [5:0] t);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
         32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
         32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
         32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
         32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      round_const = k[t];
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] i);
      logic [31:0] h [8];
      h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      init_hash = h[i];
   endfunction

endpackage

// File: hw/rtl/sha_stream_if.sv
interface sha_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/sha256_hash_engine.sv
// A byte beat is taken while ready is high; the 64th byte of a block then
// holds ready low for the 64 rounds plus the fold step.
// A finish beat runs one compression, or two with a length-block load between
// them for the pad, then emits eight result beats, one per cycle while
// rsp_ready is high.
// Throughput is set by the single shared round unit: one round per cycle.
// Reset (synchronous, active high) restores the initial hash and empties the
// byte count; window and working registers are left undefined.
module sha256_hash_engine import sha_pkg::*; (
   input logic  clock,
   input logic  reset,
   sha_stream_if.sink   req,
   sha_stream_if.source rsp
);
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PAD  = 5'b00010,
      ST_RUN  = 5'b00100,
      ST_FOLD = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] hash_ff [8];
   logic [31:0] hash_in [8];
   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [255:0] work_ff, work_in, work_nx;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] oidx_ff, oidx_in;
   logic second_ff, second_in;  // a length-only block still follows
   logic finish_ff, finish_in;  // current compression belongs to a finish
   logic [31:0] w_cur, x15, x2, x7, sm0, sm1;
   logic [5:0] pos;
   logic [3:0] widx;
   logic [4:0] shamt;
   logic [63:0] bits;
   req_type rq;

   assign rq = req.payload;
   assign pos = count_ff[5:0];
   assign widx = round_ff[3:0];
   assign bits = {count_ff, 3'b000};

   always_comb begin
      x15 = win_ff[widx + 4'd1];
      x2  = win_ff[widx + 4'd14];
      x7  = win_ff[widx + 4'd9];
      sm0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
      sm1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
      w_cur = (round_ff < 6'd16) ? win_ff[widx] : sm1 + x7 + sm0 + win_ff[widx];
   end

   sha_round u_round (.work_in(work_ff), .w(w_cur), .t(round_ff), .work_out(work_nx));

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.payload = '{hash_word: hash_ff[oidx_ff], word_index: oidx_ff,
                          last: (oidx_ff == 3'd7)};

   always_comb begin
      state_in = state_ff;
      hash_in = hash_ff;
      win_in = win_ff;
      work_in = work_ff;
      count_in = count_ff;
      round_in = round_ff;
      oidx_in = oidx_ff;
      second_in = second_ff;
      finish_in = finish_ff;
      shamt = 5'(24 - 8 * int'(pos[1:0]));
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               // drop the byte (or pad) into its word, zeroing the word on lane 0
               if (pos[1:0] == 2'd0) win_in[pos[5:2]] = '0;
               if (rq.op == OP_BYTE) begin
                  win_in[pos[5:2]] = win_in[pos[5:2]] | (32'(rq.data_byte) << shamt);
                  count_in = count_ff + 1'b1;
                  finish_in = 1'b0;
                  if (pos == 6'd63) begin
                     state_in = ST_RUN;
                     round_in = '0;
                     work_in = {hash_ff[0], hash_ff[1], hash_ff[2], hash_ff[3],
                                hash_ff[4], hash_ff[5], hash_ff[6], hash_ff[7]};
                  end
               end else begin
                  win_in[pos[5:2]] = win_in[pos[5:2]] | (32'(PadByte) << shamt);
                  for (int k = 0; k < 16; k++) begin
                     if (4'(k) > pos[5:2]) win_in[k] = '0;
                  end
                  finish_in = 1'b1;
                  second_in = (pos >= 6'd56);
                  if (pos < 6'd56) begin
                     win_in[14] = bits[63:32];
                     win_in[15] = bits[31:0];
                  end
                  state_in = ST_RUN;
                  round_in = '0;
                  work_in = {hash_ff[0], hash_ff[1], hash_ff[2], hash_ff[3],
                             hash_ff[4], hash_ff[5], hash_ff[6], hash_ff[7]};
               end
            end
         end
         ST_PAD: begin
            // load the length-only block
            for (int k = 0; k < 14; k++) win_in[k] = '0;
            win_in[14] = bits[63:32];
            win_in[15] = bits[31:0];
            second_in = 1'b0;
            round_in = '0;
            work_in = {hash_ff[0], hash_ff[1], hash_ff[2], hash_ff[3],
                       hash_ff[4], hash_ff[5], hash_ff[6], hash_ff[7]};
            state_in = ST_RUN;
         end
         ST_RUN: begin
            work_in = work_nx;
            win_in[widx] = w_cur;
            round_in = round_ff + 1'b1;
            if (round_ff == 6'(Rounds - 1)) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            for (int k = 0; k < 8; k++)
               hash_in[k] = hash_ff[k] + work_ff[255 - 32*k -: 32];
            if (!finish_ff) state_in = ST_IDLE;
            else if (second_ff) state_in = ST_PAD;
            else begin
               state_in = ST_OUT;
               oidx_in = '0;
            end
         end
         ST_OUT: begin
            if (rsp.ready) begin
               oidx_in = oidx_ff + 1'b1;
               if (oidx_ff == 3'd7) begin
                  // advance to a fresh message
                  for (int k = 0; k < 8; k++) hash_in[k] = init_hash(3'(k));
                  count_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         round_ff <= '0;
         oidx_ff <= '0;
         second_ff <= 1'b0;
         finish_ff <= 1'b0;
         for (int k = 0; k < 8; k++) hash_ff[k] <= init_hash(3'(k));
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         round_ff <= round_in;
         oidx_ff <= oidx_in;
         second_ff <= second_in;
         finish_ff <= finish_in;
         hash_ff <= hash_in;
      end
      win_ff <= win_in;
      work_ff <= work_in;
   end

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(oidx_ff))
      else $error("result beat dropped while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> !req.ready)
      else $error("input accepted during compression");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.payload.last |=> state_ff == ST_IDLE && count_ff == '0)
      else $error("engine not rearmed after digest");
endmodule

// File: hw/rtl/sha_round.sv
module sha_round import sha_pkg::*; (
   input  logic [255:0] work_in,
   input  logic [31:0]  w,
   input  logic [5:0]   t,
   output logic [255:0] work_out
);
   logic [31:0] a, b, c, d, e, f, g, h, t1, t2, ch, maj, s0, s1;
   always_comb begin
      {a, b, c, d, e, f, g, h} = work_in;
      ch  = (e & f) ^ (~e & g);
      maj = (a & b) ^ (a & c) ^ (b & c);
      s0  = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
      s1  = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
      t1  = h + s1 + ch + round_const(t) + w;
      t2  = s0 + maj;
      work_out = {t1 + t2, a, b, c, d + t1, e, f, g};
   end
endmodule

// File: test/tb_sha256_hash_engine.sv
module tb_sha256_hash_engine;
   import sha_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #10 clock = ~clock;

   // request and response channels
   sha_stream_if #(.payload_type(req_type)) req_ch ();
   sha_stream_if #(.payload_type(rsp_type)) rsp_ch ();

   sha256_hash_engine dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // predictor state: chaining value, open block and byte count
   logic [31:0] chain_h [8];
   logic [31:0] block_w [16];
   logic [60:0] msg_bytes;

   // digest words still owed by the block, oldest first
   rsp_type digest_q [$];

   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;

   localparam int CycleLimit = 400000;

   localparam logic [31:0] InitH [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
      32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // run 64 rounds over block_w and fold into chain_h
   task automatic compress_block();
      logic [31:0] s [8];
      logic [31:0] sched [64];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++) sched[i] = block_w[i];
      for (int i = 16; i < 64; i++)
         sched[i] = (ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10))
                  + sched[i-7]
                  + (ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3))
                  + sched[i-16];
      for (int i = 0; i < 8; i++) s[i] = chain_h[i];
      for (int t = 0; t < 64; t++) begin
         t1 = s[7] + (ror32(s[4], 6) ^ ror32(s[4], 11) ^ ror32(s[4], 25))
            + ((s[4] & s[5]) ^ (~s[4] & s[6])) + RoundK[t] + sched[t];
         t2 = (ror32(s[0], 2) ^ ror32(s[0], 13) ^ ror32(s[0], 22))
            + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
         for (int i = 7; i > 0; i--) s[i] = s[i-1];
         s[4] = s[4] + t1;
         s[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + s[i];
   endtask

   // place one byte big-endian at a block position
   task automatic place_byte(input int pos, input logic [7:0] b);
      if ((pos & 3) == 0) block_w[pos >> 2] = '0;
      block_w[pos >> 2][24 - 8 * (pos & 3) +: 8] = b;
   endtask

   // advance the predictor by one accepted request beat
   task automatic hash_predict(input req_type r);
      int pos;
      int k;
      logic [63:0] bit_len;
      pos = int'(msg_bytes[5:0]);
      if (r.op == OP_BYTE) begin
         place_byte(pos, r.data_byte);
         msg_bytes = msg_bytes + 1'b1;
         if (pos == 63) compress_block();
      end else begin
         place_byte(pos, PadByte);
         k = (pos >> 2) + 1;
         // pad near block end: close this block, then a length-only block
         if (pos >= 56) begin
            for (; k < 16; k++) block_w[k] = '0;
            compress_block();
            k = 0;
         end
         for (; k < 14; k++) block_w[k] = '0;
         bit_len = {msg_bytes, 3'b000};
         block_w[14] = bit_len[63:32];
         block_w[15] = bit_len[31:0];
         compress_block();
         for (int i = 0; i < 8; i++)
            digest_q.push_back('{hash_word: chain_h[i], word_index: 3'(i), last: (i == 7)});
         chain_h = InitH;
         msg_bytes = '0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
      error_count++;
   endtask

   // hold off the receiver for a long stretch while the sender keeps going
   always @(posedge clock) begin
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_sha256_hash_engine: FAIL");
         $finish;
      end
   end

   // receiver: randomize ready, check each accepted beat against the oldest digest word
   initial rsp_ch.ready = 1'b0;
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (digest_q.size() == 0) begin
            report_mismatch("unexpected beat", rsp_ch.payload.hash_word, '0);
         end else begin
            want = digest_q.pop_front();
            if (rsp_ch.payload.hash_word !== want.hash_word)
               report_mismatch("hash_word", rsp_ch.payload.hash_word, want.hash_word);
            if (rsp_ch.payload.word_index !== want.word_index)
               report_mismatch("word_index", rsp_ch.payload.word_index, want.word_index);
            if (rsp_ch.payload.last !== want.last)
               report_mismatch("last", rsp_ch.payload.last, want.last);
         end
      end
      rsp_ch.ready <= !reset && hold_cycles == 0 && ($urandom_range(99) >= recv_idle_pct);
   end

   // send one request beat, idling at random beforehand; valid stays up until idle or done
   task automatic send_req(input logic op, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= '{op: op, data_byte: b};
      do @(posedge clock); while (!req_ch.ready);
      hash_predict('{op: op, data_byte: b});
   endtask

   // drop valid, then wait for every owed digest word
   task automatic drain_digests();
      req_ch.valid <= 1'b0;
      while (digest_q.size() != 0) @(posedge clock);
   endtask

   // directed rows; want0 is the first digest word of a finish row where it reads at a glance
   typedef struct {
      logic        op;
      logic [7:0]  data_byte;
      bit          check_h0;
      logic [31:0] want0;
   } dir_row;

   dir_row dir_rows [] = '{
      '{OP_FINISH, 8'h00, 1'b1, 32'he3b0c442},   // empty message
      '{OP_BYTE,   8'h61, 1'b0, 32'h0},
      '{OP_BYTE,   8'h62, 1'b0, 32'h0},
      '{OP_BYTE,   8'h63, 1'b0, 32'h0},
      '{OP_FINISH, 8'h00, 1'b1, 32'hba7816bf},   // "abc"
      '{OP_BYTE,   8'h00, 1'b0, 32'h0},
      '{OP_BYTE,   8'hff, 1'b0, 32'h0},
      '{OP_BYTE,   8'haa, 1'b0, 32'h0},
      '{OP_BYTE,   8'h55, 1'b0, 32'h0},
      '{OP_FINISH, 8'hff, 1'b0, 32'h0},          // data ignored on finish
      '{OP_FINISH, 8'h00, 1'b1, 32'he3b0c442}    // back-to-back empty
   };

   task automatic run_message(input int n_bytes);
      for (int i = 0; i < n_bytes; i++) send_req(OP_BYTE, 8'($urandom_range(255)));
      send_req(OP_FINISH, 8'($urandom_range(255)));
   endtask

   int lens [] = '{55, 56, 63, 64};

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      chain_h = InitH;
      msg_bytes = '0;
      for (int i = 0; i < 16; i++) block_w[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part; typed-in first words are checked against the predictor
      foreach (dir_rows[i]) begin
         send_req(dir_rows[i].op, dir_rows[i].data_byte);
         if (dir_rows[i].check_h0 && digest_q.size() >= 8 &&
             digest_q[digest_q.size() - 8].hash_word !== dir_rows[i].want0)
            report_mismatch("table digest", digest_q[digest_q.size() - 8].hash_word,
                            dir_rows[i].want0);
      end
      // pad boundary lengths
      foreach (lens[i]) run_message(lens[i]);
      drain_digests();

      // random messages under three idling mixes
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 51 : 0;
         recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 14 : 0;
         if (phase == 2) hold_cycles = 600;   // long receiver stall while bytes keep coming
         for (int m = 0; m < 8; m++)
            run_message($urandom_range(0, 9));
      end

      drain_digests();
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("tb_sha256_hash_engine: PASS");
      else
         $display("tb_sha256_hash_engine: FAIL");
      $finish;
   end

endmodule
